/* src/aarch64_branch_predecode_defines.svh */
// Assertion macros shared by the checker.
`ifndef AARCH64_BRANCH_PREDECODE_DEFINES_SVH
`define AARCH64_BRANCH_PREDECODE_DEFINES_SVH

// Same-cycle implication.
`define A64BP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("branch predecode check failed");

// Implication with a delayed consequent.
`define A64BP_ASSERT_LATER2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("branch predecode latency check failed");

`endif

/* src/a64bp_pkg.sv */
`timescale 1ns / 1ps

package a64bp_pkg;

  typedef enum logic [3:0] {
    KIND_NONE  = 4'd0,
    KIND_BCOND = 4'd1,
    KIND_B     = 4'd2,
    KIND_BL    = 4'd3,
    KIND_BLR   = 4'd4,
    KIND_CBZ   = 4'd5,
    KIND_CBNZ  = 4'd6,
    KIND_TBZ   = 4'd7,
    KIND_TBNZ  = 4'd8
  } a64bp_kind_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] pc;
  } a64bp_in_t;

  typedef struct packed {
    a64bp_kind_t branch_kind;
    logic        target_valid;
    logic [63:0] target;
  } a64bp_out_t;

  localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
  localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;
  localparam logic [31:0] B_MASK      = 32'hFC00_0000;
  localparam logic [31:0] B_MATCH     = 32'h1400_0000;
  localparam logic [31:0] BL_MATCH    = 32'h9400_0000;
  localparam logic [31:0] BLR_MASK    = 32'hFFFF_FC1F;
  localparam logic [31:0] BLR_MATCH   = 32'hD63F_0000;
  localparam logic [31:0] CB_MASK     = 32'h7F00_0000;
  localparam logic [31:0] CBZ_MATCH   = 32'h3400_0000;
  localparam logic [31:0] CBNZ_MATCH  = 32'h3500_0000;
  localparam logic [31:0] TBZ_MATCH   = 32'h3600_0000;
  localparam logic [31:0] TBNZ_MATCH  = 32'h3700_0000;

endpackage

/* src/aarch64_branch_predecode.sv */
`timescale 1ns / 1ps
// The start transfer passes through in_vld_r and then out_vld_r, which drives the out_valid strobe.
// Throughput: one instruction word per cycle; busy is never raised.
// Stages: input register, then classify plus one 64-bit target add into the result register.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset (rst_n low, synchronous) clears both valid flags; payload registers are not reset.

module aarch64_branch_predecode
  import a64bp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  a64bp_in_t  in_item,
  output logic       out_valid,
  output a64bp_out_t out_result
);

  logic        in_vld_r;
  a64bp_in_t   in_r;
  logic        out_vld_r;
  a64bp_out_t  out_r;
  a64bp_out_t  out_nxt;

  a64bp_kind_t kind;
  logic [31:0] w;
  logic [63:0] offset;

  assign busy = 1'b0;
  assign w    = in_r.instruction;

  always_comb begin
    priority if ((w & BCOND_MASK) == BCOND_MATCH) kind = KIND_BCOND;
    else if ((w & B_MASK) == B_MATCH)             kind = KIND_B;
    else if ((w & B_MASK) == BL_MATCH)            kind = KIND_BL;
    else if ((w & BLR_MASK) == BLR_MATCH)         kind = KIND_BLR;
    else if ((w & CB_MASK) == CBZ_MATCH)          kind = KIND_CBZ;
    else if ((w & CB_MASK) == CBNZ_MATCH)         kind = KIND_CBNZ;
    else if ((w & CB_MASK) == TBZ_MATCH)          kind = KIND_TBZ;
    else if ((w & CB_MASK) == TBNZ_MATCH)         kind = KIND_TBNZ;
    else                                          kind = KIND_NONE;
  end

  always_comb begin
    out_nxt.branch_kind = kind;
    unique case (kind)
      KIND_BCOND, KIND_CBZ, KIND_CBNZ: begin
        offset               = {{43{w[23]}}, w[23:5], 2'b00};
        out_nxt.target_valid = 1'b1;
        out_nxt.target       = in_r.pc + offset;
      end
      KIND_TBZ, KIND_TBNZ: begin
        offset               = {{48{w[18]}}, w[18:5], 2'b00};
        out_nxt.target_valid = 1'b1;
        out_nxt.target       = in_r.pc + offset;
      end
      default: begin
        offset               = 64'd0;
        out_nxt.target_valid = 1'b0;
        out_nxt.target       = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  // hold payload until the next transfer
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_r;

endmodule

/* src/a64bp_checker.sv */
`timescale 1ns / 1ps
`include "aarch64_branch_predecode_defines.svh"

module a64bp_checker
  import a64bp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input a64bp_out_t out_result
);

  logic       taken;
  logic       cond_kind;
  a64bp_kind_t k;

  assign taken     = start && !busy;
  assign k         = out_result.branch_kind;
  assign cond_kind = (k == KIND_BCOND) || (k == KIND_CBZ) || (k == KIND_CBNZ) ||
                     (k == KIND_TBZ) || (k == KIND_TBNZ);

  `A64BP_ASSERT_LATER2(a_latency, taken, out_valid)
  `A64BP_ASSERT_NOW(a_no_invented, out_valid, $past(taken && rst_n, 2))
  `A64BP_ASSERT_NOW(a_never_busy, 1'b1, !busy)
  `A64BP_ASSERT_NOW(a_valid_kind, out_valid, out_result.target_valid == cond_kind)
  `A64BP_ASSERT_NOW(a_zero_target, out_valid && !out_result.target_valid,
                    out_result.target == 64'd0)

endmodule

bind aarch64_branch_predecode a64bp_checker u_a64bp_checker (.*);

/* tb/sv/aarch64_branch_predecode_tb.sv */
`timescale 1ns / 1ps

module aarch64_branch_predecode_tb;
  import a64bp_pkg::*;

  localparam int STALL_LIMIT  = 500;
  localparam int PHASE_ITEMS  = 158;
  localparam int SETTLE_TICKS = 4;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  a64bp_in_t  in_item;
  logic       out_valid;
  a64bp_out_t out_result;

  int quiet_cycles;

  class predecode_sb;
    a64bp_out_t target_q[$];
    int         errors;

    function a64bp_kind_t classify(logic [31:0] w);
      if ((w & BCOND_MASK) == BCOND_MATCH) return KIND_BCOND;
      if ((w & B_MASK) == B_MATCH)         return KIND_B;
      if ((w & B_MASK) == BL_MATCH)        return KIND_BL;
      if ((w & BLR_MASK) == BLR_MATCH)     return KIND_BLR;
      if ((w & CB_MASK) == CBZ_MATCH)      return KIND_CBZ;
      if ((w & CB_MASK) == CBNZ_MATCH)     return KIND_CBNZ;
      if ((w & CB_MASK) == TBZ_MATCH)      return KIND_TBZ;
      if ((w & CB_MASK) == TBNZ_MATCH)     return KIND_TBNZ;
      return KIND_NONE;
    endfunction

    function a64bp_out_t predict_branch(a64bp_in_t item);
      logic [31:0] w;
      a64bp_out_t  r;
      w = item.instruction;
      r.branch_kind  = classify(w);
      r.target_valid = 1'b0;
      r.target       = '0;
      case (r.branch_kind)
        KIND_BCOND, KIND_CBZ, KIND_CBNZ: begin
          r.target_valid = 1'b1;
          r.target       = item.pc + {{43{w[23]}}, w[23:5], 2'b00};
        end
        KIND_TBZ, KIND_TBNZ: begin
          r.target_valid = 1'b1;
          r.target       = item.pc + {{48{w[18]}}, w[18:5], 2'b00};
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(a64bp_in_t item);
      target_q.push_back(predict_branch(item));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(a64bp_out_t got);
      a64bp_out_t exp_r;
      if (target_q.size() == 0) begin
        report("result with no transfer outstanding");
        return;
      end
      exp_r = target_q.pop_front();
      if (got.branch_kind !== exp_r.branch_kind)
        report($sformatf("branch_kind %0d, want %0d", got.branch_kind, exp_r.branch_kind));
      if (got.target_valid !== exp_r.target_valid)
        report($sformatf("target_valid %0b, want %0b", got.target_valid, exp_r.target_valid));
      if (got.target !== exp_r.target)
        report($sformatf("target %h, want %h", got.target, exp_r.target));
    endtask
  endclass

  predecode_sb sb = new();

  aarch64_branch_predecode i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_item);
      if (out_valid) sb.check_result(out_result);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(logic [31:0] w, logic [63:0] pc, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{instruction: w, pc: pc};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.target_q.size() != 0);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 11))
      0, 1: ;
      2: begin
        w[31:24] = BCOND_MATCH[31:24];
        w[4]     = 1'b0;
      end
      3: w[31:26] = B_MATCH[31:26];
      4: w[31:26] = BL_MATCH[31:26];
      5: w = BLR_MATCH | (32'($urandom_range(0, 31)) << 5);
      6: w[30:24] = CBZ_MATCH[30:24];
      7: w[30:24] = CBNZ_MATCH[30:24];
      8: w[30:24] = TBZ_MATCH[30:24];
      9: w[30:24] = TBNZ_MATCH[30:24];
      10: begin
        w        = BLR_MATCH | (32'($urandom_range(0, 31)) << 5);
        w[$urandom_range(0, 4)] = 1'b1;
      end
      default: begin
        w[31:24] = BCOND_MATCH[31:24];
        w[4]     = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [63:0] random_pc();
    case ($urandom_range(0, 3))
      0:       return {32'h0, 16'h0, 16'($urandom())};
      1:       return {32'hFFFF_FFFF, 16'hFFFF, 16'($urandom())};
      default: return {32'($urandom()), 32'($urandom())};
    endcase
  endfunction

  initial begin
    static int idle_pct [4] = '{0, 56, 0, 24};
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(BCOND_MATCH | (32'h3FFFF << 5) | 32'hF, 64'h0, 0);
    send_word(BCOND_MATCH | (32'h40000 << 5), 64'h0, 0);
    send_word(BCOND_MATCH | (32'h1 << 5), 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(BCOND_MATCH | 32'h0000_0010, 64'h1234, 0);
    send_word(32'h17FF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(BL_MATCH, 64'h8000_0000_0000_0000, 0);
    send_word(BLR_MATCH | (32'd31 << 5), 64'h4000, 0);
    send_word(BLR_MATCH | 32'h1, 64'h4000, 0);
    send_word(CBZ_MATCH, 64'h0, 0);
    send_word(32'hB4FF_FFFF, 64'h0, 0);
    send_word(CBNZ_MATCH | (32'h3FFFF << 5), 64'hFFFF_FFFF_FFFF_FFF0, 0);
    send_word(32'hB580_0000, 64'h10, 0);
    send_word(TBZ_MATCH, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(32'hB603_FFE0, 64'h0, 0);
    send_word(TBZ_MATCH | 32'h0004_0000, 64'h0, 0);
    send_word(32'h37FF_FFFF, 64'h0, 0);
    send_word(32'hB7F8_001F, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_word(32'hD65F_03C0, 64'h5555_AAAA_5555_AAAA, 0);
    drain_results();

    foreach (idle_pct[p]) begin
      repeat (PHASE_ITEMS) send_word(random_word(), random_pc(), idle_pct[p]);
      drain_results();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
